// ----- rtl/sat_pkg.sv -----
// ----------------------------------------------------------------------------
// sat_pkg
// Types and codes shared by the set-associative score table modules.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int KEY_W   = 32;
  localparam int SCORE_W = 32;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score_in;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [SCORE_W-1:0] score_out;
    logic                      written;
  } rsp_t;

  // One slot of a bucket row; the score is kept as raw two's complement bits.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } slot_t;

  typedef struct packed {
    logic load;   // capture the request and read its bucket
    logic scan;   // examine one way of the bucket
    logic fin;    // write back and issue the result
    logic clr;    // zero one bucket row and advance
  } ctl_t;

  typedef struct packed {
    logic scan_last;
    logic clr_last;
  } stat_t;

endpackage

// ----- rtl/sat_ram.sv -----
// ----------------------------------------------------------------------------
// sat_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer for the score table: clearing sweep, way scan and write-back.
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sat_pkg::CMD_W-1:0]    in_cmd,
  input  sat_pkg::stat_t               stat,
  output sat_pkg::ctl_t                ctl,
  output logic                         busy
);
  import sat_pkg::*;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       report_r, report_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    ctl        = '0;
    unique case (state_r)
      ST_CLR: begin
        ctl.clr = 1'b1;
        if (stat.clr_last) begin
          // A clear command reports once the sweep is done; reset does not.
          state_nxt  = report_r ? ST_FIN : ST_IDLE;
          report_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          if (in_cmd == CMD_CLEAR) begin
            state_nxt  = ST_CLR;
            report_nxt = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
    end
  end

endmodule

// ----- rtl/sat_dp.sv -----
// ----------------------------------------------------------------------------
// sat_dp
// Datapath: bucket RAM, per-way scan registers, write-back and result.
// ----------------------------------------------------------------------------
module sat_dp #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sat_pkg::req_t  in_data,
  input  sat_pkg::ctl_t  ctl,
  output sat_pkg::stat_t stat,
  output logic           out_strobe,
  output sat_pkg::rsp_t  out_data
);
  import sat_pkg::*;

  localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * $bits(slot_t);
  localparam logic [BW-1:0] BMASK    = BW'(NUM_BUCKETS - 1);
  localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);
  localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

  typedef slot_t [WAYS-1:0] row_t;

  // Request registers.
  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [SCORE_W-1:0] score_r;
  logic [BW-1:0]      addr_r;

  // Scan state.
  logic [WW-1:0]      way_r;
  logic               found_r, empty_r, low_r;
  logic [WW-1:0]      fway_r, eway_r, lway_r;
  logic [SCORE_W-1:0] fscore_r, lscore_r;
  logic [BW-1:0]      clr_addr_r;

  logic               out_strobe_r;
  rsp_t               out_r;

  row_t               rd_row, wr_row;
  logic [ROW_W-1:0]   rd_bits;
  slot_t              cur;
  logic               first;
  logic               found_p, empty_p, low_p;
  logic               way_hit, way_empty, take_low;
  logic               do_wr, ram_we;
  logic [WW-1:0]      wway;
  logic [BW-1:0]      ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  rsp_t               rsp;

  sat_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.load),
    .raddr (in_data.key[BW-1:0] & BMASK),
    .rdata (rd_bits)
  );

  assign rd_row         = row_t'(rd_bits);
  assign cur            = rd_row[way_r];
  assign first          = (way_r == '0);
  assign stat.scan_last = (way_r == LAST_WAY);
  assign stat.clr_last  = (clr_addr_r == LAST_ROW);

  // Accumulators as they stand before this way; the first way starts fresh.
  assign found_p = first ? 1'b0 : found_r;
  assign empty_p = first ? 1'b0 : empty_r;
  assign low_p   = first ? 1'b0 : low_r;

  // An all-zero slot is empty; occupied slots compete for the lowest score.
  assign way_hit   = (cur.key == key_r);
  assign way_empty = (cur.key == '0) && (cur.score == '0);
  assign take_low  = !way_empty &&
                     (!low_p || ($signed(cur.score) < $signed(lscore_r)));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_data.cmd;
      key_r   <= in_data.key;
      score_r <= in_data.score_in;
      addr_r  <= in_data.key[BW-1:0] & BMASK;
    end
    if (ctl.scan) begin
      // First matching way wins.
      found_r <= found_p || way_hit;
      if (!found_p && way_hit) begin
        fway_r   <= way_r;
        fscore_r <= cur.score;
      end
      // The last empty slot seen is kept.
      empty_r <= empty_p || way_empty;
      if (way_empty) begin
        eway_r <= way_r;
      end
      low_r <= low_p || take_low;
      if (take_low) begin
        lway_r   <= way_r;
        lscore_r <= cur.score;
      end
    end
    out_r <= rsp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_r        <= '0;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (ctl.scan) begin
        way_r <= stat.scan_last ? '0 : way_r + 1'b1;
      end
      if (ctl.clr) begin
        clr_addr_r <= stat.clr_last ? '0 : clr_addr_r + 1'b1;
      end
      out_strobe_r <= ctl.fin;
    end
  end

  // Insert decision and result.
  always_comb begin
    do_wr = 1'b0;
    wway  = lway_r;
    rsp   = '0;
    case (cmd_r)
      CMD_LOOKUP: begin
        rsp.hit       = found_r;
        rsp.score_out = found_r ? $signed(fscore_r) : '0;
      end
      CMD_INSERT: begin
        if (found_r) begin
          wway  = fway_r;
          do_wr = $signed(fscore_r) < $signed(score_r);
        end else if (empty_r) begin
          wway  = eway_r;
          do_wr = 1'b1;
        end else begin
          wway  = lway_r;
          do_wr = low_r;
        end
        rsp.written = do_wr;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (wway == WW'(w)) begin
        wr_row[w].key   = key_r;
        wr_row[w].score = score_r;
      end
    end
  end

  assign ram_we    = ctl.clr || (ctl.fin && do_wr);
  assign ram_waddr = ctl.clr ? clr_addr_r : addr_r;
  assign ram_wdata = ctl.clr ? '0 : ROW_W'(wr_row);

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ----- rtl/set_assoc_score_table.sv -----
// ----------------------------------------------------------------------------
// set_assoc_score_table
// Set-associative table of (key, score) slots with lookup, insert and clear.
//
//   channel   ports                         transfer when
//   -------   ---------------------------   ------------------------------
//   request   start, busy, in_data          start high and busy low
//   result    out_strobe, out_data          out_strobe high (one cycle)
//
// Lookup and insert first read the bucket row, then scan the ways one per
// cycle, then write back. The result strobes in the cycle after the
// write-back. A clear command sweeps the RAM one bucket row per cycle,
// then reports. After reset the same sweep runs with busy high.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module set_assoc_score_table #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sat_pkg::req_t in_data,
  output logic          out_strobe,
  output sat_pkg::rsp_t out_data
);
  import sat_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  sat_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  sat_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // An accepted request always keeps the block busy for the next cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  // Results never come in consecutive cycles.
  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A result never flags both a lookup hit and an insert write.
  a_hit_written : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.hit && out_data.written))
    else $error("result flags both hit and written");

  // The controller drives only one datapath command per cycle.
  a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.scan, ctl.fin, ctl.clr}))
    else $error("conflicting datapath commands");

endmodule

// ----- sim/set_assoc_score_table_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_score_table_tb
// Self-checking bench for the set-associative score table. Each accepted
// request goes through a shadow copy of the table. The shadow copy yields the
// response the block owes, and every response strobe is compared with the
// oldest pending prediction, field by field. A directed table covers empty
// and full buckets, key zero, score extremes, clear and the unused command.
// Random phases follow. They work a handful of crowded buckets so that
// replacement and score raising happen often, under changing sender gaps.
// ----------------------------------------------------------------------------
module set_assoc_score_table_tb;
  import sat_pkg::*;

  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS        = 4;
  localparam int SLOTS       = NUM_BUCKETS * WAYS;
  localparam int RAND_ITEMS  = 626;
  localparam int POOL_SIZE   = 16;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [KEY_W-1:0] BUCKET_MASK = NUM_BUCKETS - 1;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } stim_row_t;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  req_t in_data = '0;
  logic busy;
  logic out_strobe;
  rsp_t out_data;

  // Shadow copy of the slot store.
  logic        [KEY_W-1:0]   tbl_key   [SLOTS];
  logic signed [SCORE_W-1:0] tbl_score [SLOTS];

  rsp_t       pending_rsp_q[$];
  stim_row_t  stim_rows[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int errors = 0;

  set_assoc_score_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i]   = '0;
      tbl_score[i] = '0;
    end
  endfunction

  // Applies one request to the shadow table and returns the response it owes.
  function automatic rsp_t table_apply(input req_t r);
    rsp_t        rsp;
    int          base;
    int          empty_way;
    int          low_way;
    bit          done;
    bit          have_empty;
    bit          have_low;
    logic [KEY_W-1:0]          k;
    logic signed [SCORE_W-1:0] s;
    rsp        = '0;
    base       = int'(r.key & BUCKET_MASK) * WAYS;
    done       = 1'b0;
    have_empty = 1'b0;
    have_low   = 1'b0;
    empty_way  = 0;
    low_way    = 0;
    case (r.cmd)
      CMD_LOOKUP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!done && tbl_key[base+w] == r.key) begin
            rsp.hit       = 1'b1;
            rsp.score_out = tbl_score[base+w];
            done          = 1'b1;
          end
        end
      end
      CMD_INSERT: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!done) begin
            k = tbl_key[base+w];
            s = tbl_score[base+w];
            if (k == r.key) begin
              // A matching key only ever has its score raised.
              if (s < r.score_in) begin
                tbl_score[base+w] = r.score_in;
                rsp.written       = 1'b1;
              end
              done = 1'b1;
            end else if (k == '0 && s == '0) begin
              have_empty = 1'b1;
              empty_way  = w;
            end else if (!have_low || s < tbl_score[base+low_way]) begin
              have_low = 1'b1;
              low_way  = w;
            end
          end
        end
        if (!done && have_empty) begin
          tbl_key[base+empty_way]   = r.key;
          tbl_score[base+empty_way] = r.score_in;
          rsp.written               = 1'b1;
        end else if (!done && have_low) begin
          tbl_key[base+low_way]   = r.key;
          tbl_score[base+low_way] = r.score_in;
          rsp.written             = 1'b1;
        end
      end
      CMD_CLEAR: wipe_table();
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                         input logic [SCORE_W-1:0] sc, input logic typed,
                         input logic h, input logic [SCORE_W-1:0] so,
                         input logic wr);
    stim_row_t row;
    row.req.cmd       = c;
    row.req.key       = k;
    row.req.score_in  = sc;
    row.typed         = typed;
    row.rsp.hit       = h;
    row.rsp.score_out = so;
    row.rsp.written   = wr;
    stim_rows.push_back(row);
  endtask

  // Keys crowd a few buckets so that buckets fill up and slots get replaced.
  task automatic refill_key_pool();
    logic [KEY_W-1:0] bucket;
    logic [KEY_W-1:0] b0;
    logic [KEY_W-1:0] b1;
    logic [KEY_W-1:0] b2;
    b0 = $urandom & BUCKET_MASK;
    b1 = $urandom & BUCKET_MASK;
    b2 = $urandom_range(0, 1) ? BUCKET_MASK : '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 2))
        0:       bucket = b0;
        1:       bucket = b1;
        default: bucket = b2;
      endcase
      key_pool[i] = ($urandom & ~BUCKET_MASK) | bucket;
    end
  endtask

  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 199);
    if (pick < 90)       r.cmd = CMD_LOOKUP;
    else if (pick < 186) r.cmd = CMD_INSERT;
    else if (pick < 188) r.cmd = CMD_CLEAR;
    else                 r.cmd = CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 75)      r.key = key_pool[$urandom_range(0, POOL_SIZE-1)];
    else if (pick < 80) r.key = '0;
    else                r.key = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.score_in = $signed($urandom_range(0, 16)) - 8;
    end else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0:       r.score_in = 32'sh8000_0000;
        1:       r.score_in = 32'sh7fff_ffff;
        2:       r.score_in = '0;
        default: r.score_in = -1;
      endcase
    end else begin
      r.score_in = $urandom;
    end
    return r;
  endfunction

  // Leaves start high on return so back-to-back requests need no toggle.
  task automatic issue(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t pred;
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = table_apply(r);
    pending_rsp_q.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < pct) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_strobe) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with nothing pending: %p", $time, out_data);
        errors++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_data.hit);
          errors++;
        end
        if (out_data.score_out !== want.score_out) begin
          $display("%0t: score_out expected %0d actual %0d", $time,
                   want.score_out, out_data.score_out);
          errors++;
        end
        if (out_data.written !== want.written) begin
          $display("%0t: written expected %0b actual %0b", $time,
                   want.written, out_data.written);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int idle_pct[4];
    int per_phase;
    idle_pct  = '{0, 81, 0, 31};
    per_phase = RAND_ITEMS / 4;
    wipe_table();

    // Bucket zero is filled through its empty ways, then overflows.
    add_row(CMD_LOOKUP, 32'h0000_0000, 32'sd0,          1, 1, 32'sd0, 0);
    add_row(CMD_LOOKUP, 32'hffff_ffff, 32'sd0,          1, 0, 32'sd0, 0);
    add_row(CMD_UNUSED, 32'h1234_5678, 32'sh7fff_ffff,  1, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_0400, 32'sh7fff_ffff,  1, 0, 32'sd0, 1);
    add_row(CMD_LOOKUP, 32'h0000_0400, 32'sd0,          1, 1, 32'sh7fff_ffff, 0);
    add_row(CMD_INSERT, 32'h0000_0400, 32'sh8000_0000,  1, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_0800, 32'sh8000_0000,  1, 0, 32'sd0, 1);
    add_row(CMD_INSERT, 32'h0000_0c00, 32'sd5,          1, 0, 32'sd0, 1);
    add_row(CMD_INSERT, 32'h0000_1000, -32'sd1,         1, 0, 32'sd0, 1);
    add_row(CMD_INSERT, 32'h0000_1400, 32'sd7,          0, 0, 32'sd0, 0);
    add_row(CMD_LOOKUP, 32'h0000_0800, 32'sd0,          0, 0, 32'sd0, 0);
    // Key zero lands in a full bucket, then behaves as an empty slot.
    add_row(CMD_INSERT, 32'h0000_0000, 32'sd0,          0, 0, 32'sd0, 0);
    add_row(CMD_LOOKUP, 32'h0000_0000, 32'sd0,          0, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_0000, 32'sd9,          0, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_0000, -32'sd3,         0, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_03ff, 32'sh8000_0000,  1, 0, 32'sd0, 1);
    add_row(CMD_LOOKUP, 32'hffff_ffff, 32'sd0,          1, 0, 32'sd0, 0);
    add_row(CMD_INSERT, 32'hffff_ffff, 32'sh7fff_ffff,  1, 0, 32'sd0, 1);
    add_row(CMD_LOOKUP, 32'hffff_ffff, 32'sd0,          1, 1, 32'sh7fff_ffff, 0);
    add_row(CMD_LOOKUP, 32'h0000_03ff, 32'sd0,          0, 0, 32'sd0, 0);
    add_row(CMD_CLEAR,  32'h0000_0400, 32'sd0,          1, 0, 32'sd0, 0);
    add_row(CMD_LOOKUP, 32'h0000_0400, 32'sd0,          1, 0, 32'sd0, 0);
    add_row(CMD_LOOKUP, 32'h0000_0000, 32'sd0,          1, 1, 32'sd0, 0);
    add_row(CMD_INSERT, 32'h0000_0000, 32'sd0,          1, 0, 32'sd0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      issue(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
    end

    for (int p = 0; p < 4; p++) begin
      // Hold the sender off until every pending response has come back.
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clk);
      refill_key_pool();
      for (int n = 0; n < per_phase; n++) begin
        sender_gap(idle_pct[p]);
        issue(random_req(), 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (WAYS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
